// ----- hw/rtl/nsr_pkg.sv -----
package nsr_pkg;

    // Field widths of the operand and the root
    localparam int VALUE_W = 32;
    localparam int ROOT_W  = 24;

    // Largest root the output field can carry
    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

// ----- hw/rtl/nsr_div.sv -----
module nsr_div #(
    parameter int W = 47
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     n_quo;
    logic [W-1:0]     r_dvs;
    logic [W-1:0]     n_dvs;
    logic [W:0]       w_shift;
    logic [W:0]       w_diff;
    logic             w_fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    // Load on start, then retire one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[W-1:0] : w_shift[W-1:0];
            n_quo = {r_quo[W-2:0], w_fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // A new division never starts on top of a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    // The last quotient bit is followed by done
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CNT_W'(1)) |=> r_done)
        else $error("divider finished without done");

    // Done is a single-cycle pulse with the unit at rest
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy ##1 !r_done)
        else $error("done pulse malformed");

endmodule

// ----- hw/rtl/newton_square_root.sv -----
// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  i_value  (signed Q15.16)
// output    out        o_valid / i_stall  o_root   (unsigned Q8.16)
//
// A positive operand keeps the input stalled until its root has been handed to
// the output register, after ITERATIONS Newton steps at a width of W bits,
// with W = 31 + FRAC_BITS (47 at the defaults). Each Newton step starts the
// shared radix-2 divider and waits for its W quotient bits and its done pulse.
// A zero or negative operand skips the divider and goes straight to hand-off
// with a zero root. Reset is synchronous, active low.
// A stalled root holds in the output register while the next word is worked.
module newton_square_root #(
    parameter int ITERATIONS = 20,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [nsr_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [nsr_pkg::ROOT_W-1:0]   o_root
);

    import nsr_pkg::*;

    localparam int W      = VALUE_W - 1 + FRAC_BITS;
    localparam int ITER_W = $clog2(ITERATIONS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [W-1:0]        r_scaled;
    logic [W-1:0]        n_scaled;
    logic [W-1:0]        r_x;
    logic [W-1:0]        n_x;
    logic [ITER_W-1:0]   r_iter;
    logic [ITER_W-1:0]   n_iter;
    logic                r_start;
    logic                n_start;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   n_root;
    logic                r_ovalid;
    logic                n_ovalid;

    logic                w_accept;
    logic                w_pos;
    logic [W-1:0]        w_half;
    logic [W-1:0]        w_guess;
    logic [W:0]          w_sum;
    logic [W-1:0]        w_next;
    logic [W-1:0]        w_next_safe;
    logic [ROOT_W-1:0]   w_sat;
    logic                w_out_free;
    logic                w_div_done;
    logic [W-1:0]        w_quot;

    // Shared divider: q = (n << FRAC_BITS) / x
    nsr_div #(
        .W(W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_scaled),
        .i_divisor  (r_x),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_pos    = !i_value[VALUE_W-1] && (i_value != '0);

    // Start from half the operand, never below one LSB
    assign w_half  = W'(i_value[VALUE_W-2:1]);
    assign w_guess = (w_half == '0) ? W'(1) : w_half;

    // Newton update x = (x + q) / 2
    assign w_sum       = {1'b0, r_x} + {1'b0, w_quot};
    assign w_next      = w_sum[W:1];
    assign w_next_safe = (w_next == '0) ? W'(1) : w_next;

    // Saturate the final guess to the root field
    assign w_sat = (r_x > W'(ROOT_MAX)) ? ROOT_MAX : r_x[ROOT_W-1:0];

    // The output register can take a word when empty or being drained
    assign w_out_free = !r_ovalid || !i_stall;

    // Sequence the iterations and hand the root to the output register
    always_comb begin
        n_state  = r_state;
        n_scaled = r_scaled;
        n_x      = r_x;
        n_iter   = r_iter;
        n_start  = 1'b0;
        n_root   = r_root;
        n_ovalid = r_ovalid;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (w_pos) begin
                        n_scaled = W'(i_value[VALUE_W-2:0]) << FRAC_BITS;
                        n_x      = w_guess;
                        n_iter   = '0;
                        n_start  = 1'b1;
                        n_state  = S_DIV;
                    end else begin
                        n_x     = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (r_iter == ITER_W'(ITERATIONS - 1)) begin
                        n_x     = w_next;
                        n_state = S_OUT;
                    end else begin
                        n_x     = w_next_safe;
                        n_iter  = r_iter + ITER_W'(1);
                        n_start = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_root   = w_sat;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iter   <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_iter   <= n_iter;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
        end
        r_scaled <= n_scaled;
        r_x      <= n_x;
        r_root   <= n_root;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_root  = r_root;

    // A non-positive operand goes straight to hand-off with a zero guess
    a_nonpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_pos) |=> (r_state == S_OUT && r_x == '0))
        else $error("non-positive operand did not give zero");

    // A positive operand starts the first iteration
    a_pos_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_pos) |=> (r_state == S_DIV && r_iter == '0 && r_start))
        else $error("positive operand did not start iterating");

    // Divider results only arrive while iterating
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside iteration");

    // A stalled root word holds its value
    a_root_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_root)))
        else $error("stalled root word changed");

endmodule
